// ===== sv/assert_macros.svh =====
// Assertion macros shared by the interpolator RTL.
// Depends on clk_i and rst_ni existing in the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define LSI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lsi assertion failed");

// Same-cycle implication.
`define LSI_ASSERT_IMP(lbl, ante, cons) `LSI_ASSERT(lbl, (ante) |-> (cons))

`endif

// ===== sv/lsi_pkg.sv =====
// Package for the line step interpolator: constants, types, state codes.
// No dependencies.
package lsi_pkg;

  localparam int FRAC_BITS       = 8;
  localparam int PARAM_FRAC_BITS = 30;
  localparam int UW              = PARAM_FRAC_BITS + 4;   // path parameter width
  localparam int LP_W            = 36;                    // line point magnitude width
  localparam int DW              = 40;                    // signed difference width
  localparam int DIST_W          = 31;

  localparam logic [UW-1:0]     U_MAX    = {UW{1'b1}};
  localparam logic [UW-1:0]     U_ONE    = UW'(1) << PARAM_FRAC_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_64 = 2'd2
  } mac_sh_e;

  typedef struct packed {
    logic    en;
    logic    clr;
    mac_sh_e sh;
  } mac_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LP1,
    S_G1,
    S_SQ,
    S_BIG,
    S_SEL,
    S_DIV,
    S_LP2,
    S_OUT
  } state_e;

endpackage

// ===== sv/lsi_mac.sv =====
// Shared 32x32 multiplier with a 128-bit shifting accumulator.
// Depends on lsi_pkg. Product registered, accumulated in the next cycle.
module lsi_mac (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lsi_pkg::mac_op_t op_i,
  input  logic [31:0]      a_i,
  input  logic [31:0]      b_i,
  output logic [127:0]     acc_o
);

  logic [63:0]      prod_q;
  lsi_pkg::mac_op_t op_q;
  logic [127:0]     acc_q;
  logic [127:0]     addend;

  always_comb begin
    case (op_q.sh)
      lsi_pkg::SH_32: addend = {32'd0, prod_q, 32'd0};
      lsi_pkg::SH_64: addend = {prod_q, 64'd0};
      default:        addend = {64'd0, prod_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '{en: 1'b0, clr: 1'b0, sh: lsi_pkg::SH_0};
    end else begin
      op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (op_q.en) begin
      acc_q <= (op_q.clr ? 128'd0 : acc_q) + addend;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== sv/lsi_div.sv =====
// Restoring divider: (dist << PARAM_FRAC_BITS) / mag, one quotient bit a cycle.
// Depends on lsi_pkg. Caller guarantees dist < 16 * mag.
module lsi_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lsi_pkg::DIST_W-1:0]        dist_i,
  input  logic [31:0]                       mag_i,
  output logic                              done_o,
  output logic [lsi_pkg::UW-1:0]            quot_o
);

  logic                       busy_q;
  logic                       done_q;
  logic [5:0]                 bit_q;
  logic [32:0]                rem_q;
  logic [lsi_pkg::UW-1:0]     quot_q;
  logic [lsi_pkg::DIST_W-1:0] dist_q;
  logic [31:0]                mag_q;
  logic [5:0]                 off;
  logic                       dbit;
  logic [32:0]                rem_sh;
  logic                       fits;

  // dividend bit: dist shifted up by the fraction width
  assign off    = bit_q - 6'(lsi_pkg::PARAM_FRAC_BITS);
  assign dbit   = (bit_q >= 6'(lsi_pkg::PARAM_FRAC_BITS)) ? dist_q[off[4:0]] : 1'b0;
  assign rem_sh = {rem_q[31:0], dbit};
  assign fits   = rem_sh >= {1'b0, mag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        bit_q  <= 6'(lsi_pkg::UW - 1);
      end else if (busy_q) begin
        bit_q <= bit_q - 6'd1;
        if (bit_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dist_q <= dist_i;
      mag_q  <= mag_i;
      rem_q  <= 33'(dist_i >> (lsi_pkg::UW - lsi_pkg::PARAM_FRAC_BITS));
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? (rem_sh - {1'b0, mag_q}) : rem_sh;
      quot_q <= {quot_q[lsi_pkg::UW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  `include "assert_macros.svh"

  `LSI_ASSERT_IMP(a_start_idle, start_i, !busy_q)
  `LSI_ASSERT(a_done_end, done_q |-> $past(busy_q) && !busy_q)
  `LSI_ASSERT_IMP(a_rem_below, busy_q, rem_q < {1'b0, mag_q})

endmodule

// ===== sv/line_step_interpolator_3d_unit.sv =====
// Three-axis straight-line step/direction interpolator, top level.
// Depends on lsi_pkg, lsi_mac, lsi_div and assert_macros.svh.
//
// Use: the slave channel takes one word per command. tuser = action:
// load (0) stores the target in tdata and restarts the segment, giving no
// result; advance (1) runs one interpolation step and gives one result
// word on the master channel: pulse byte and direction byte in tdata,
// segment done on tlast.
// Flow: a load is accepted in S_IDLE and the input stays ready. Advance
// with no active segment: result valid the cycle after acceptance. Active
// advance: the result passes through S_LP1, S_G1, S_SQ, S_BIG, S_SEL,
// S_DIV, S_LP2 and S_OUT; S_DIV is skipped when the increment saturates.
// The time is set by the shared 32x32 multiply-accumulate (28 partial
// products for line points and ratio tests, with product and sum
// registered) and the bit-serial divider (34 quotient bits, then a registered done).
// One word is in flight at a time: tready is low while working and while
// a result is still held for the receiver; it rises the cycle after the
// result is taken, so a stalled receiver simply holds the block idle.
// Reset clears target, u, position and the active flag; an advance after
// reset reports segment done with no pulses.
module line_step_interpolator_3d_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // delta_x[31:0], delta_y[63:32], delta_z[95:64]
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // pulse_byte[5:0], dir_byte[11:6], zero pad
  output logic        m_axis_tlast    // segment_done
);

  localparam int UW = lsi_pkg::UW;
  localparam int DW = lsi_pkg::DW;
  localparam logic signed [DW-1:0] STEP_S  = DW'(1) <<< lsi_pkg::FRAC_BITS;
  localparam logic signed [DW-1:0] HALF_S  = DW'(1) <<< (lsi_pkg::FRAC_BITS - 1);
  localparam logic signed [DW-1:0] POS_MAX = DW'(32'h7FFF_FFFF);
  localparam logic signed [DW-1:0] POS_MIN = -(DW'(1) <<< 31);

  lsi_pkg::state_e  state_q, state_d;
  logic [3:0]       sub_q, sub_d;
  logic [1:0]       ax_q, ax_d;
  lsi_pkg::mac_op_t op;
  logic [31:0]      mac_a, mac_b;
  logic [127:0]     acc;
  logic             div_start, div_done;
  logic [UW-1:0]    quot;

  // segment state
  logic             active_q;
  logic [UW-1:0]    u_q;
  logic [31:0]      m_q   [3];
  logic             sgn_q [3];
  logic [31:0]      pos_q [3];
  // working registers
  logic [30:0]      d_q   [3];
  logic [63:0]      t_q, sd_q, sm_q, m2sq_q, d2sq_q;
  logic [127:0]     lhs_q;
  logic             g1_q, g2_q;
  logic [5:0]       pulse_q, dir_q;
  logic             out_valid_q;
  logic [11:0]      out_data_q;
  logic             out_last_q;

  logic             in_acc;
  logic [63:0]      u64, a64, b64;
  logic [1:0]       pj;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == lsi_pkg::S_IDLE) && !out_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_data_q};
  assign m_axis_tlast  = out_last_q;
  assign u64           = 64'(u_q);

  // line point of the current axis from the accumulator
  logic [lsi_pkg::LP_W-1:0] lp;
  logic signed [DW-1:0]     lp_s, line, pos_s, diff1, adiff1, diff2;
  logic [30:0]              dsat;
  logic                     step_up, step_dn;

  assign lp     = acc[lsi_pkg::PARAM_FRAC_BITS +: lsi_pkg::LP_W];
  assign lp_s   = signed'({{(DW - lsi_pkg::LP_W){1'b0}}, lp});
  assign line   = sgn_q[ax_q] ? -lp_s : lp_s;
  assign pos_s  = signed'({{(DW - 32){pos_q[ax_q][31]}}, pos_q[ax_q]});
  assign diff1  = line - pos_s + (sgn_q[ax_q] ? STEP_S : -STEP_S);
  assign adiff1 = diff1[DW-1] ? -diff1 : diff1;
  assign dsat   = (adiff1 > signed'(DW'(lsi_pkg::DIST_MAX))) ? lsi_pkg::DIST_MAX
                                                              : adiff1[30:0];
  assign diff2   = line - pos_s;
  assign step_up = (diff2 > HALF_S) && (pos_s + STEP_S <= POS_MAX);
  assign step_dn = (diff2 < -HALF_S) && (pos_s - STEP_S >= POS_MIN);

  // plane choice; a zero component is never picked
  logic [1:0]    sel;
  logic [30:0]   d_sel;
  logic [31:0]   m_sel;
  logic          big;
  logic [UW:0]   usum;
  logic [UW-1:0] inc;

  always_comb begin
    if (m_q[2] != 32'd0 && ((m_q[0] == 32'd0 && m_q[1] == 32'd0) || g2_q)) begin
      sel = 2'd2;
    end else if (m_q[1] != 32'd0 && (m_q[0] == 32'd0 || g1_q)) begin
      sel = 2'd1;
    end else begin
      sel = 2'd0;
    end
  end

  assign d_sel = d_q[sel];
  assign m_sel = m_q[sel];
  assign big   = {5'd0, d_sel} >= {m_sel, 4'd0};   // integer part of 16 or more
  assign inc   = (quot == '0) ? UW'(1) : quot;
  assign usum  = {1'b0, u_q} + {1'b0, inc};

  // 64x64 partial product selection for the wide ratio test
  assign pj  = sub_q[1:0];
  assign a64 = (sub_q < 4'd4) ? m2sq_q : d2sq_q;
  assign b64 = (sub_q < 4'd4) ? sd_q   : sm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsi_pkg::S_IDLE;
      sub_q   <= '0;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      ax_q    <= ax_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    sub_d     = sub_q;
    ax_d      = ax_q;
    op        = '{en: 1'b0, clr: 1'b0, sh: lsi_pkg::SH_0};
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    unique case (state_q) inside
      lsi_pkg::S_IDLE: begin
        if (in_acc && s_axis_tuser == lsi_pkg::ACT_ADVANCE && active_q) begin
          state_d = lsi_pkg::S_LP1;
          sub_d   = '0;
          ax_d    = '0;
        end
      end
      lsi_pkg::S_LP1, lsi_pkg::S_LP2: begin
        mac_a  = m_q[ax_q];
        mac_b  = sub_q[0] ? u64[63:32] : u64[31:0];
        op.en  = sub_q < 4'd2;
        op.clr = sub_q == 4'd0;
        op.sh  = sub_q[0] ? lsi_pkg::SH_32 : lsi_pkg::SH_0;
        sub_d  = sub_q + 4'd1;
        if (sub_q == 4'd3) begin
          sub_d = '0;
          if (ax_q == 2'd2) begin
            ax_d    = '0;
            state_d = (state_q == lsi_pkg::S_LP1) ? lsi_pkg::S_G1 : lsi_pkg::S_OUT;
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end
      end
      lsi_pkg::S_G1: begin
        sub_d = sub_q + 4'd1;
        case (sub_q)
          4'd0: begin
            mac_a = m_q[1];
            mac_b = {1'b0, d_q[0]};
            op    = '{en: 1'b1, clr: 1'b1, sh: lsi_pkg::SH_0};
          end
          4'd2: begin
            mac_a = m_q[0];
            mac_b = {1'b0, d_q[1]};
            op    = '{en: 1'b1, clr: 1'b1, sh: lsi_pkg::SH_0};
          end
          4'd4: begin
            sub_d   = '0;
            state_d = lsi_pkg::S_SQ;
          end
          default: ;
        endcase
      end
      lsi_pkg::S_SQ: begin
        sub_d = sub_q + 4'd1;
        case (sub_q)
          4'd0: begin
            mac_a = {1'b0, d_q[0]};
            mac_b = {1'b0, d_q[0]};
            op    = '{en: 1'b1, clr: 1'b1, sh: lsi_pkg::SH_0};
          end
          4'd1: begin
            mac_a = {1'b0, d_q[1]};
            mac_b = {1'b0, d_q[1]};
            op    = '{en: 1'b1, clr: 1'b0, sh: lsi_pkg::SH_0};
          end
          4'd2: begin
            mac_a = m_q[0];
            mac_b = m_q[0];
            op    = '{en: 1'b1, clr: 1'b1, sh: lsi_pkg::SH_0};
          end
          4'd3: begin
            mac_a = m_q[1];
            mac_b = m_q[1];
            op    = '{en: 1'b1, clr: 1'b0, sh: lsi_pkg::SH_0};
          end
          4'd4: begin
            mac_a = m_q[2];
            mac_b = m_q[2];
            op    = '{en: 1'b1, clr: 1'b1, sh: lsi_pkg::SH_0};
          end
          4'd5: begin
            mac_a = {1'b0, d_q[2]};
            mac_b = {1'b0, d_q[2]};
            op    = '{en: 1'b1, clr: 1'b1, sh: lsi_pkg::SH_0};
          end
          4'd7: begin
            sub_d   = '0;
            state_d = lsi_pkg::S_BIG;
          end
          default: ;
        endcase
      end
      lsi_pkg::S_BIG: begin
        sub_d  = sub_q + 4'd1;
        mac_a  = pj[1] ? a64[63:32] : a64[31:0];
        mac_b  = pj[0] ? b64[63:32] : b64[31:0];
        op.en  = sub_q < 4'd8;
        op.clr = pj == 2'd0;
        case (pj)
          2'd0:    op.sh = lsi_pkg::SH_0;
          2'd3:    op.sh = lsi_pkg::SH_64;
          default: op.sh = lsi_pkg::SH_32;
        endcase
        if (sub_q == 4'd9) begin
          sub_d   = '0;
          state_d = lsi_pkg::S_SEL;
        end
      end
      lsi_pkg::S_SEL: begin
        if (big) begin
          state_d = lsi_pkg::S_LP2;
        end else begin
          div_start = 1'b1;
          state_d   = lsi_pkg::S_DIV;
        end
        sub_d = '0;
        ax_d  = '0;
      end
      lsi_pkg::S_DIV: begin
        if (div_done) begin
          state_d = lsi_pkg::S_LP2;
        end
      end
      lsi_pkg::S_OUT: begin
        state_d = lsi_pkg::S_IDLE;
      end
      default: state_d = lsi_pkg::S_IDLE;
    endcase
  end

  // control and segment state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      u_q         <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        m_q[k]   <= '0;
        sgn_q[k] <= 1'b0;
        pos_q[k] <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        lsi_pkg::S_IDLE: begin
          if (in_acc && s_axis_tuser == lsi_pkg::ACT_LOAD) begin
            for (int k = 0; k < 3; k++) begin
              sgn_q[k] <= s_axis_tdata[32*k+31];
              m_q[k]   <= s_axis_tdata[32*k+31] ? -s_axis_tdata[32*k +: 32]
                                                : s_axis_tdata[32*k +: 32];
              pos_q[k] <= '0;
            end
            u_q      <= '0;
            active_q <= |s_axis_tdata;
          end else if (in_acc && !active_q) begin
            out_valid_q <= 1'b1;
          end
        end
        lsi_pkg::S_SEL: begin
          if (big) begin
            u_q <= lsi_pkg::U_MAX;
          end
        end
        lsi_pkg::S_DIV: begin
          if (div_done) begin
            u_q <= (usum > {1'b0, lsi_pkg::U_MAX}) ? lsi_pkg::U_MAX : usum[UW-1:0];
          end
        end
        lsi_pkg::S_LP2: begin
          if (sub_q == 4'd3) begin
            if (step_up) begin
              pos_q[ax_q] <= pos_q[ax_q] + 32'(STEP_S);
            end else if (step_dn) begin
              pos_q[ax_q] <= pos_q[ax_q] - 32'(STEP_S);
            end
          end
        end
        lsi_pkg::S_OUT: begin
          out_valid_q <= 1'b1;
          if (u_q > lsi_pkg::U_ONE) begin
            active_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and result word
  always_ff @(posedge clk_i) begin
    case (state_q)
      lsi_pkg::S_IDLE: begin
        pulse_q <= '0;
        dir_q   <= '0;
        if (in_acc && s_axis_tuser == lsi_pkg::ACT_ADVANCE && !active_q) begin
          out_data_q <= '0;
          out_last_q <= 1'b1;
        end
      end
      lsi_pkg::S_LP1: begin
        if (sub_q == 4'd3) begin
          d_q[ax_q] <= dsat;
        end
      end
      lsi_pkg::S_G1: begin
        if (sub_q == 4'd2) t_q  <= acc[63:0];
        if (sub_q == 4'd4) g1_q <= t_q >= acc[63:0];
      end
      lsi_pkg::S_SQ: begin
        if (sub_q == 4'd3) sd_q   <= acc[63:0];
        if (sub_q == 4'd5) sm_q   <= acc[63:0];
        if (sub_q == 4'd6) m2sq_q <= acc[63:0];
        if (sub_q == 4'd7) d2sq_q <= acc[63:0];
      end
      lsi_pkg::S_BIG: begin
        if (sub_q == 4'd5) lhs_q <= acc;
        if (sub_q == 4'd9) g2_q  <= lhs_q >= acc;
      end
      lsi_pkg::S_LP2: begin
        if (sub_q == 4'd3) begin
          for (int k = 0; k < 3; k++) begin
            if (ax_q == 2'(k)) begin
              if (step_up) begin
                pulse_q[2*k] <= 1'b1;
              end else if (step_dn) begin
                pulse_q[2*k]   <= 1'b1;
                pulse_q[2*k+1] <= 1'b1;
                dir_q[2*k+1]   <= 1'b1;
              end
            end
          end
        end
      end
      lsi_pkg::S_OUT: begin
        out_data_q <= {dir_q, pulse_q};
        out_last_q <= u_q > lsi_pkg::U_ONE;
      end
      default: ;
    endcase
  end

  lsi_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  lsi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dist_i  (d_sel),
    .mag_i   (m_sel),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  `include "assert_macros.svh"

  `LSI_ASSERT_IMP(a_rdy_idle, s_axis_tready, state_q == lsi_pkg::S_IDLE)
  `LSI_ASSERT_IMP(a_div_sel, div_start, state_q == lsi_pkg::S_SEL)
  `LSI_ASSERT_IMP(a_out_active, state_q == lsi_pkg::S_OUT, active_q)
  `LSI_ASSERT(a_u_mono, !(in_acc && s_axis_tuser == lsi_pkg::ACT_LOAD) |=> u_q >= $past(u_q))

endmodule

// ===== bench/testbench.sv =====
// Testbench for line_step_interpolator_3d_unit: random and directed load and
// advance words, with a step predictor held in a small scoreboard class.
// Depends on lsi_pkg and the interpolator RTL.
module testbench;

  // Step predictor and the queue of pulse words it expects.
  class step_board;
    logic signed [63:0] tgt [3];
    logic signed [63:0] cpos [3];
    logic [63:0] u;
    bit running;
    logic [12:0] pulse_q [$];
    int errors;
    int seen;

    function void clear();
      for (int k = 0; k < 3; k++) begin
        tgt[k] = 0;
        cpos[k] = 0;
      end
      u = 0;
      running = 0;
      errors = 0;
      seen = 0;
    endfunction

    // target*u >> PARAM_FRAC_BITS on the magnitude, sign reapplied
    function logic signed [63:0] line_at(logic signed [63:0] c, logic [63:0] uu);
      logic [127:0] p;
      logic [63:0] m;
      m = (c < 0) ? -c : c;
      p = m * uu;
      p = p >> lsi_pkg::PARAM_FRAC_BITS;
      return (c < 0) ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

    function void note_word(lsi_pkg::action_e act, logic [95:0] d);
      logic [63:0] m [3], dst [3], inc, q, r;
      logic signed [63:0] diff;
      logic [255:0] lhs, rhs;
      logic [12:0] res;
      bit g1, g2;
      int sel;
      if (act == lsi_pkg::ACT_LOAD) begin
        for (int k = 0; k < 3; k++) begin
          tgt[k] = $signed(d[32*k +: 32]);
          cpos[k] = 0;
        end
        u = 0;
        running = (tgt[0] != 0) || (tgt[1] != 0) || (tgt[2] != 0);
        return;
      end
      res = '0;
      if (!running) begin
        res[12] = 1'b1;
        pulse_q.push_back(res);
        return;
      end
      for (int k = 0; k < 3; k++) begin
        diff = line_at(tgt[k], u) - cpos[k];
        diff += (tgt[k] >= 0) ? -64'sd256 : 64'sd256;
        m[k] = (tgt[k] < 0) ? -tgt[k] : tgt[k];
        dst[k] = (diff < 0) ? -diff : diff;
        if (dst[k] > 64'h7FFF_FFFF) dst[k] = 64'h7FFF_FFFF;
      end
      g1 = m[1] * dst[0] >= m[0] * dst[1];
      lhs = 256'(m[2] * m[2]) * 256'(dst[0] * dst[0] + dst[1] * dst[1]);
      rhs = 256'(dst[2] * dst[2]) * 256'(m[0] * m[0] + m[1] * m[1]);
      g2 = lhs >= rhs;
      if (m[2] != 0 && ((m[0] == 0 && m[1] == 0) || g2)) sel = 2;
      else if (m[1] != 0 && (m[0] == 0 || g1)) sel = 1;
      else sel = 0;
      q = dst[sel] / m[sel];
      r = dst[sel] % m[sel];
      if (q >= 16) inc = lsi_pkg::U_MAX;
      else begin
        inc = ((q << lsi_pkg::PARAM_FRAC_BITS) |
               ((r << lsi_pkg::PARAM_FRAC_BITS) / m[sel]));
        if (inc == 0) inc = 1;
      end
      u = u + inc;
      if (u > lsi_pkg::U_MAX) u = lsi_pkg::U_MAX;
      for (int k = 0; k < 3; k++) begin
        diff = line_at(tgt[k], u) - cpos[k];
        if (diff > 128 && cpos[k] + 256 <= 64'sh7FFF_FFFF) begin
          cpos[k] += 256;
          res[2*k] = 1'b1;
        end else if (diff < -128 && cpos[k] - 256 >= -64'sh8000_0000) begin
          cpos[k] -= 256;
          res[2*k] = 1'b1;
          res[2*k+1] = 1'b1;
          res[6+2*k+1] = 1'b1;
        end
      end
      if (u > lsi_pkg::U_ONE) begin
        running = 0;
        res[12] = 1'b1;
      end
      pulse_q.push_back(res);
    endfunction

    task check_word(logic [15:0] got, logic got_last);
      logic [12:0] want;
      seen++;
      if (pulse_q.size() == 0) begin
        report_miss("unexpected word", 0, got);
        return;
      end
      want = pulse_q.pop_front();
      if (got[5:0] != want[5:0]) report_miss("pulse_byte", want[5:0], got[5:0]);
      if (got[11:6] != want[11:6]) report_miss("dir_byte", want[11:6], got[11:6]);
      if (got_last != want[12]) report_miss("segment_done", want[12], got_last);
    endtask

    task report_miss(string what, logic [15:0] want, logic [15:0] got);
      errors++;
      $display("mismatch %s: want %h got %h (word %0d)", what, want, got, seen);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  step_board board;
  int src_idle;     // percent chance of a gap before each word
  int sink_stall;   // percent chance of holding tready low
  int hold_off;     // cycles of forced receiver hold-off
  int cycles;
  int n_loads, n_adv;

  line_step_interpolator_3d_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: fails the run once the generous cycle limit is passed.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: sample at rising edge, drive tready at falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata, m_axis_tlast);
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall);
    end
  end

  // Offer one word and wait for acceptance; tvalid drops only on a gap or in drain.
  task automatic send_word(lsi_pkg::action_e act, logic [95:0] d);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_word(act, d);
    if (act == lsi_pkg::ACT_LOAD) n_loads++;
    else n_adv++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pulse_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return $urandom_range(2047) - 1024;
      2: return $urandom_range(8191) - 4096;
      3: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
      4: return $urandom;
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  // A segment: load, then advances until done or max_adv, plus one more.
  task automatic run_segment(logic [95:0] d, int max_adv);
    int k;
    send_word(lsi_pkg::ACT_LOAD, d);
    k = 0;
    while (k < max_adv && board.running) begin
      send_word(lsi_pkg::ACT_ADVANCE, {$urandom, $urandom, $urandom});
      k++;
    end
    send_word(lsi_pkg::ACT_ADVANCE, '0);
  endtask

  initial begin
    board = new();
    board.clear();
    cycles = 0;
    hold_off = 0;
    src_idle = 0;
    sink_stall = 0;
    n_loads = 0;
    n_adv = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = lsi_pkg::ACT_LOAD;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: idle advance after reset, zero segment, axis extremes,
    // single axes, a tiny increment and a saturated one.
    send_word(lsi_pkg::ACT_ADVANCE, '0);
    run_segment('0, 2);
    run_segment({32'd0, 32'd0, 32'd1024}, 8);
    run_segment({32'd0, -32'sd768, 32'd0}, 8);
    run_segment({32'd512, 32'd0, 32'd0}, 3);
    run_segment({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 4);
    run_segment({32'd1, 32'hFFFF_FFFF, 32'd1}, 2);
    run_segment({32'd300, -32'sd700, 32'd900}, 8);

    // Random phases with varying gap and stall rates.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0; sink_stall = 0; end
        1: begin src_idle = 64; sink_stall = 0; end
        2: begin src_idle = 0; sink_stall = 64; end
        default: begin src_idle = 13; sink_stall = 13; end
      endcase
      if (ph == 2) hold_off = 400;  // long receiver hold-off, sender keeps offering
      while (n_loads + n_adv < 325 * (ph + 1)) begin
        if ($urandom_range(9) == 0)
          send_word(lsi_pkg::action_e'($urandom_range(1)), {$urandom, $urandom, $urandom});
        else
          run_segment({pick_delta(), pick_delta(), pick_delta()}, 12);
      end
      drain();  // sender pauses until every result is in
    end
    drain();

    $display("covered %0d loads and %0d advances, %0d result words checked",
             n_loads, n_adv, board.seen);
    if (board.errors == 0 && board.pulse_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/lsi_pkg.sv
sv/lsi_mac.sv
sv/lsi_div.sv
sv/line_step_interpolator_3d_unit.sv
bench/testbench.sv
